>>> rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int unsigned BlockBits = 512;
  localparam int unsigned ChainLen  = 8;
  localparam logic [7:0]  PadByte   = 8'h80;
  localparam logic [5:0]  LenFill   = 6'd56;
  localparam logic        CmdAbsorb = 1'b0;
  localparam logic        CmdFinish = 1'b1;

  typedef struct packed {
    logic       is_finish;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic start;
    logic restart;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
  } core_stat_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] r;
    case (idx)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> rtl/sha256_stream_hasher_top.sv
// An absorb item is shifted into the block register; a full block adds a compression.
// A finish item adds padding and one or two compressions, then eight digest items
// leave one per cycle through the output register while the receiver is ready.
// Throughput: one byte per cycle between blocks, limited by the single round unit.
// Reset: asynchronous active low; chaining words return to the initial hash values.
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 over a byte stream with an input queue and a round-serial core.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top import shs_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  logic                 item_valid, pop;
  item_t                item;
  core_ctrl_t           ctrl;
  core_stat_t           stat;
  logic [BlockBits-1:0] block;
  logic [31:0]          chain [ChainLen];

  shs_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .data_byte_i,
    .item_valid_o(item_valid), .item_o(item), .pop_i(pop)
  );

  shs_back u_back (
    .clk_i, .rst_ni, .item_valid_i(item_valid), .item_i(item), .pop_o(pop),
    .ctrl_o(ctrl), .block_o(block), .stat_i(stat), .chain_i(chain),
    .out_valid_o, .out_ready_i, .digest_word_o, .word_index_o, .last_word_o
  );

  shs_core u_core (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .block_i(block), .stat_o(stat), .chain_o(chain)
  );

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.start |-> !stat.busy) else $error("block started while core busy");
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_word_o |-> word_index_o == 3'd7) else $error("bad last word");
  a_restart_iv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.restart |=> chain[0] == 32'h6a09e667) else $error("chain not restarted");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> !pop) else $error("item taken during compression");
`endif

endmodule

>>> rtl/shs_front.sv
// ----------------------------------------------------------------------------
// shs_front
// Input queue: accepts items, tags finish items and buffers them for the back.
// ----------------------------------------------------------------------------
module shs_front import shs_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic [7:0] data_byte_i,
  output logic       item_valid_o,
  output item_t      item_o,
  input  logic       pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign in_ready_o   = (cnt_q != CntW'(Depth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && item_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q].is_finish <= (command_i == CmdFinish);
      mem_q[wr_q].data      <= data_byte_i;
    end
  end

endmodule

>>> rtl/shs_core.sv
// ----------------------------------------------------------------------------
// shs_core
// SHA-256 compression: one round per cycle over a 16-word schedule window.
// ----------------------------------------------------------------------------
module shs_core import shs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  core_ctrl_t           ctrl_i,
  input  logic [BlockBits-1:0] block_i,
  output core_stat_t           stat_o,
  output logic [31:0]          chain_o [ChainLen]
);

  logic [31:0] chain_q [ChainLen];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  rnd_q;
  logic        busy_q, fin_q;
  logic [31:0] t1, t2, ch, mj, w_new, s0, s1;

  assign stat_o.busy = busy_q;
  assign chain_o     = chain_q;

  always_comb begin
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    mj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1    = v_q[7] + (ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25)) + ch
            + round_k(rnd_q) + w_q[0];
    t2    = (ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22)) + mj;
    s0    = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
    s1    = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = s1 + w_q[9] + s0 + w_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ChainLen; i++) chain_q[i] <= iv_word(3'(i));
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      rnd_q  <= '0;
    end else begin
      if (ctrl_i.restart) begin
        for (int i = 0; i < ChainLen; i++) chain_q[i] <= iv_word(3'(i));
      end else if (fin_q) begin
        for (int i = 0; i < ChainLen; i++) chain_q[i] <= chain_q[i] + v_q[i];
      end
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (fin_q) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 1'b1;
        if (rnd_q == 6'd63) begin
          fin_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= chain_q[i];
      for (int i = 0; i < 16; i++) w_q[i] <= block_i[BlockBits-1-32*i -: 32];
    end else if (busy_q && !fin_q) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
    end
  end

endmodule

>>> rtl/shs_back.sv
// ----------------------------------------------------------------------------
// shs_back
// Block assembly, padding sequencer and digest output register.
// ----------------------------------------------------------------------------
module shs_back import shs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  item_t                item_i,
  output logic                 pop_o,
  output core_ctrl_t           ctrl_o,
  output logic [BlockBits-1:0] block_o,
  input  core_stat_t           stat_i,
  input  logic [31:0]          chain_i [ChainLen],
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          digest_word_o,
  output logic [2:0]           word_index_o,
  output logic                 last_word_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPadz = 3'd1;
  localparam logic [2:0] StLen  = 3'd2;
  localparam logic [2:0] StComp = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]           state_q, state_d, ret_q, ret_d;
  logic [5:0]           fill_q;
  logic [63:0]          bits_q, bits_d;
  logic [2:0]           len_q, len_d, oidx_q, oidx_d;
  logic [BlockBits-1:0] block_q;
  logic                 shift_en, out_load;
  logic [7:0]           shift_byte;
  logic                 out_valid_q, last_q;
  logic [31:0]          word_q;
  logic [2:0]           widx_q;

  // the core takes the block together with the byte that completes it
  assign block_o       = {block_q[BlockBits-9:0], shift_byte};
  assign out_valid_o   = out_valid_q;
  assign digest_word_o = word_q;
  assign word_index_o  = widx_q;
  assign last_word_o   = last_q;

  always_comb begin
    state_d        = state_q;
    ret_d          = ret_q;
    bits_d         = bits_q;
    len_d          = len_q;
    oidx_d         = oidx_q;
    shift_en       = 1'b0;
    shift_byte     = '0;
    pop_o          = 1'b0;
    out_load       = 1'b0;
    ctrl_o.restart = 1'b0;
    case (state_q)
      StIdle: begin
        if (item_valid_i) begin
          pop_o    = 1'b1;
          shift_en = 1'b1;
          if (item_i.is_finish) begin
            shift_byte = PadByte;
            ret_d      = StPadz;
            state_d    = StPadz;
          end else begin
            shift_byte = item_i.data;
            bits_d     = bits_q + 64'd8;
            ret_d      = StIdle;
          end
        end
      end
      StPadz: begin
        if (fill_q == LenFill) begin
          state_d = StLen;
          len_d   = '0;
        end else begin
          shift_en = 1'b1;
          ret_d    = StPadz;
        end
      end
      StLen: begin
        shift_en   = 1'b1;
        shift_byte = 8'(bits_q >> (6'd56 - {len_q, 3'b000}));
        len_d      = len_q + 1'b1;
        ret_d      = StOut;
        oidx_d     = '0;
      end
      StComp: begin
        if (!stat_i.busy) begin
          state_d = ret_q;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          oidx_d   = oidx_q + 1'b1;
          if (oidx_q == 3'd7) begin
            ctrl_o.restart = 1'b1;
            bits_d         = '0;
            state_d        = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
    // a full block hands over to the compression core
    ctrl_o.start = shift_en && (fill_q == 6'd63);
    if (ctrl_o.start) begin
      state_d = StComp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ret_q       <= StIdle;
      fill_q      <= '0;
      bits_q      <= '0;
      len_q       <= '0;
      oidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      bits_q  <= bits_d;
      len_q   <= len_d;
      oidx_q  <= oidx_d;
      if (shift_en) begin
        fill_q <= fill_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      block_q <= {block_q[BlockBits-9:0], shift_byte};
    end
    if (out_load) begin
      word_q <= chain_i[oidx_q];
      widx_q <= oidx_q;
      last_q <= (oidx_q == 3'd7);
    end
  end

endmodule
